// ===== hw/rtl/taef_pkg.sv =====
`timescale 1ns / 1ps

package taef_pkg;

  // Storage geometry
  localparam int MAX_WIDTH = 4096;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int DIM_W     = 13;
  localparam int TEXEL_W   = 32;
  localparam int SLOT_W    = 2;
  localparam int ADDR_W    = SLOT_W + COL_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int PEND_W    = COL_W + 2;
  localparam int SUM_W     = 11;
  localparam int CNT_W     = 4;
  localparam int QUO_W     = 8;
  localparam int REM_W     = 3;

  // Gather and divide sequencing
  localparam logic [3:0] GATHER_TAPS  = 4'd9;
  localparam logic [3:0] CENTER_TAP   = 4'd4;
  localparam logic [3:0] DIVIDE_STEPS = 4'd8;

  // Configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FILL_ENABLE  = 2'd2;

  // Input item kinds
  localparam logic ACT_TEXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // Alpha classes
  localparam logic [1:0] CLASS_OPAQUE = 2'd0;
  localparam logic [1:0] CLASS_BINARY = 2'd1;
  localparam logic [1:0] CLASS_FULL   = 2'd2;

  // Neighbor offset codes
  localparam logic [1:0] OFF_NEG  = 2'd0;
  localparam logic [1:0] OFF_ZERO = 2'd1;
  localparam logic [1:0] OFF_POS  = 2'd2;

  localparam logic [7:0] ALPHA_OPAQUE   = 8'hFF;
  localparam logic [7:0] ALPHA_FULL_LIM = 8'hFE;
  localparam logic [7:0] GRAY_TOL       = 8'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GATHER,
    ST_DIVIDE,
    ST_EMIT
  } taef_state_t;

  typedef struct packed {
    logic accept;
    logic gather;
    logic divide;
    logic emit;
  } taef_cmd_t;

  typedef struct packed {
    logic emit_req;
    logic gather_done;
    logic div_done;
    logic out_free;
  } taef_sts_t;

endpackage

// ===== hw/rtl/texture_alpha_edge_fill_analyze_core.sv =====
`timescale 1ns / 1ps

// Alpha edge fill and analysis for one RGBA8 image sent in raster order.
// Texels come out in input order, image_width+1 texels behind the input;
// after the last texel of the image, flush transactions (tuser = 1) drain
// the remaining outputs one each. An input transaction that produces an
// output is accepted, then the nine window taps are read through the
// single read port of the four-row line memory, the bit-serial divider
// runs, and the output register is loaded, plus any wait for that
// register to be taken; no new transaction is accepted until then.
// Configuration is written through cfg_we/cfg_index/cfg_data while
// the block is idle; writing the width or height starts a new image.
module texture_alpha_edge_fill_analyze_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [taef_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [taef_pkg::DIM_W-1:0]         cfg_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [31:0]                        s_axis_tdata,  // texel_in
  input  logic                               s_axis_tuser,  // action
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [31:0]                        m_axis_tdata,  // texel_out
  output logic                               m_axis_tlast,
  output logic [2:0]                         m_axis_tuser   // alpha_class, gray_like
);

  taef_pkg::taef_cmd_t cmd;
  taef_pkg::taef_sts_t sts;
  logic [1:0]          out_class;
  logic                out_gray;

  taef_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (s_axis_tvalid),
    .item_ready (s_axis_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  taef_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_action (s_axis_tuser),
    .item_texel  (s_axis_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_texel   (m_axis_tdata),
    .out_last    (m_axis_tlast),
    .out_class   (out_class),
    .out_gray    (out_gray)
  );

  assign m_axis_tuser = {out_gray, out_class};

endmodule

// ===== hw/rtl/taef_ctrl.sv =====
`timescale 1ns / 1ps

module taef_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  taef_pkg::taef_sts_t sts,
  output taef_pkg::taef_cmd_t cmd
);

  taef_pkg::taef_state_t state;
  taef_pkg::taef_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= taef_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      taef_pkg::ST_IDLE: begin
        if (item_valid && sts.emit_req) state_next = taef_pkg::ST_GATHER;
      end
      taef_pkg::ST_GATHER: begin
        if (sts.gather_done) state_next = taef_pkg::ST_DIVIDE;
      end
      taef_pkg::ST_DIVIDE: begin
        if (sts.div_done) state_next = taef_pkg::ST_EMIT;
      end
      taef_pkg::ST_EMIT: begin
        if (sts.out_free) state_next = taef_pkg::ST_IDLE;
      end
      default: state_next = taef_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    item_ready = 1'b0;
    cmd        = '0;
    case (state)
      taef_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        cmd.accept = item_valid;
      end
      taef_pkg::ST_GATHER: cmd.gather = 1'b1;
      taef_pkg::ST_DIVIDE: cmd.divide = 1'b1;
      taef_pkg::ST_EMIT:   cmd.emit   = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hw/rtl/taef_dp.sv =====
`timescale 1ns / 1ps

module taef_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [taef_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [taef_pkg::DIM_W-1:0]           cfg_data,
  input  logic                                 item_action,
  input  logic [taef_pkg::TEXEL_W-1:0]         item_texel,
  input  taef_pkg::taef_cmd_t                  cmd,
  output taef_pkg::taef_sts_t                  sts,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [taef_pkg::TEXEL_W-1:0]         out_texel,
  output logic                                 out_last,
  output logic [1:0]                           out_class,
  output logic                                 out_gray
);

  localparam int COL_W = taef_pkg::COL_W;
  localparam int DIM_W = taef_pkg::DIM_W;

  // Configuration registers
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic             fill_reg;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;

  // Position tracking
  logic [COL_W-1:0]            in_col;
  logic [DIM_W-1:0]            in_row;
  logic [COL_W-1:0]            out_col;
  logic [DIM_W-1:0]            out_row;
  logic [taef_pkg::PEND_W-1:0] pending;
  logic [1:0]                  alpha_need;
  logic                        gray_flag;

  // Line memory holding four rows
  logic [taef_pkg::TEXEL_W-1:0] mem [taef_pkg::MEM_DEPTH];
  logic [taef_pkg::ADDR_W-1:0]  wr_addr;
  logic [taef_pkg::ADDR_W-1:0]  rd_addr;
  logic                         store;

  // Gather state
  logic [taef_pkg::CNT_W-1:0]   gcnt;
  logic [1:0]                   dr;
  logic [1:0]                   dc;
  logic                         tap_ok;
  logic [taef_pkg::SLOT_W-1:0]  tap_slot;
  logic [COL_W-1:0]             tap_col;
  logic                         rd_pend;
  logic                         rd_ok;
  logic                         rd_center;
  logic [taef_pkg::TEXEL_W-1:0] rd_data;
  logic [taef_pkg::TEXEL_W-1:0] center;
  logic [taef_pkg::SUM_W-1:0]   s0;
  logic [taef_pkg::SUM_W-1:0]   s1;
  logic [taef_pkg::SUM_W-1:0]   s2;
  logic [3:0]                   ncount;

  // Divider state
  logic [taef_pkg::CNT_W-1:0]   dcnt;
  logic [taef_pkg::QUO_W-1:0]   q0;
  logic [taef_pkg::QUO_W-1:0]   q1;
  logic [taef_pkg::QUO_W-1:0]   q2;
  logic [taef_pkg::REM_W-1:0]   r0;
  logic [taef_pkg::REM_W-1:0]   r1;
  logic [taef_pkg::REM_W-1:0]   r2;
  logic [taef_pkg::REM_W:0]     st0;
  logic [taef_pkg::REM_W:0]     st1;
  logic [taef_pkg::REM_W:0]     st2;

  // Result and trackers
  logic                         complete;
  logic                         col_end;
  logic                         is_last;
  logic [taef_pkg::TEXEL_W-1:0] res;
  logic [1:0]                   need_next;
  logic                         gray_next;

  // One restoring step: returns the quotient bit over the new remainder.
  function automatic logic [taef_pkg::REM_W:0] div_step(
    input logic [taef_pkg::REM_W-1:0] rem,
    input logic                       dbit,
    input logic [3:0]                 den
  );
    logic [taef_pkg::REM_W:0] trial;
    logic [taef_pkg::REM_W:0] diff;
    trial = {rem, dbit};
    diff  = trial - den;
    if (trial >= den) return {1'b1, diff[taef_pkg::REM_W-1:0]};
    return {1'b0, trial[taef_pkg::REM_W-1:0]};
  endfunction

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Effective image size.
  always_comb begin
    if (width_reg == '0) begin
      w_eff = DIM_W'(1);
    end else if (width_reg > DIM_W'(taef_pkg::MAX_WIDTH)) begin
      w_eff = DIM_W'(taef_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_reg;
    end
    h_eff = (height_reg == '0) ? DIM_W'(1) : height_reg;
  end

  // Item decision: store a texel, and whether a result is due.
  always_comb begin
    complete = (in_row >= h_eff);
    store    = cmd.accept && (item_action == taef_pkg::ACT_TEXEL) && !complete;
    col_end  = ((COL_W+1)'(in_col) + 1'b1) == (COL_W+1)'(w_eff);
    if (complete) begin
      sts.emit_req = (pending != '0);
    end else if (item_action == taef_pkg::ACT_TEXEL) begin
      sts.emit_req = (pending >= (taef_pkg::PEND_W'(w_eff) + 1'b1));
    end else begin
      sts.emit_req = 1'b0;
    end
    sts.gather_done = (gcnt == taef_pkg::GATHER_TAPS);
    sts.div_done    = (dcnt == taef_pkg::DIVIDE_STEPS);
    sts.out_free    = !out_valid || out_ready;
    wr_addr         = {in_row[taef_pkg::SLOT_W-1:0], in_col};
  end

  // Neighbor tap selection and bounds.
  always_comb begin
    case (gcnt)
      4'd0:    begin dr = taef_pkg::OFF_NEG;  dc = taef_pkg::OFF_NEG;  end
      4'd1:    begin dr = taef_pkg::OFF_NEG;  dc = taef_pkg::OFF_ZERO; end
      4'd2:    begin dr = taef_pkg::OFF_NEG;  dc = taef_pkg::OFF_POS;  end
      4'd3:    begin dr = taef_pkg::OFF_ZERO; dc = taef_pkg::OFF_NEG;  end
      4'd4:    begin dr = taef_pkg::OFF_ZERO; dc = taef_pkg::OFF_ZERO; end
      4'd5:    begin dr = taef_pkg::OFF_ZERO; dc = taef_pkg::OFF_POS;  end
      4'd6:    begin dr = taef_pkg::OFF_POS;  dc = taef_pkg::OFF_NEG;  end
      4'd7:    begin dr = taef_pkg::OFF_POS;  dc = taef_pkg::OFF_ZERO; end
      default: begin dr = taef_pkg::OFF_POS;  dc = taef_pkg::OFF_POS;  end
    endcase
    tap_ok   = 1'b1;
    tap_slot = out_row[taef_pkg::SLOT_W-1:0];
    tap_col  = out_col;
    case (dr)
      taef_pkg::OFF_NEG: begin
        tap_ok   = (out_row != '0);
        tap_slot = out_row[taef_pkg::SLOT_W-1:0] - 1'b1;
      end
      taef_pkg::OFF_POS: begin
        tap_ok   = ((out_row + 1'b1) != h_eff);
        tap_slot = out_row[taef_pkg::SLOT_W-1:0] + 1'b1;
      end
      default: ;
    endcase
    case (dc)
      taef_pkg::OFF_NEG: begin
        tap_ok  = tap_ok && (out_col != '0);
        tap_col = out_col - 1'b1;
      end
      taef_pkg::OFF_POS: begin
        tap_ok  = tap_ok && (((COL_W+1)'(out_col) + 1'b1) != (COL_W+1)'(w_eff));
        tap_col = out_col + 1'b1;
      end
      default: ;
    endcase
    rd_addr = {tap_slot, tap_col};
  end

  // Line memory: one write port for incoming texels, one registered read port.
  always_ff @(posedge clk) begin
    if (store) begin
      mem[wr_addr] <= item_texel;
    end
    if (cmd.gather && (gcnt < taef_pkg::GATHER_TAPS)) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Gather sequencing and neighbor accumulation.
  always_ff @(posedge clk) begin
    if (rst) begin
      gcnt    <= '0;
      rd_pend <= 1'b0;
    end else if (cmd.accept) begin
      gcnt    <= '0;
      rd_pend <= 1'b0;
    end else if (cmd.gather) begin
      if (gcnt < taef_pkg::GATHER_TAPS) begin
        gcnt    <= gcnt + 1'b1;
        rd_pend <= 1'b1;
      end else begin
        rd_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s0     <= '0;
      s1     <= '0;
      s2     <= '0;
      ncount <= '0;
    end else if (cmd.gather) begin
      if (gcnt < taef_pkg::GATHER_TAPS) begin
        rd_ok     <= tap_ok;
        rd_center <= (gcnt == taef_pkg::CENTER_TAP);
      end
      if (rd_pend) begin
        if (rd_center) begin
          center <= rd_data;
        end else if (rd_ok && (rd_data[31:24] == taef_pkg::ALPHA_OPAQUE)) begin
          s2     <= s2 + taef_pkg::SUM_W'(rd_data[23:16]);
          s1     <= s1 + taef_pkg::SUM_W'(rd_data[15:8]);
          s0     <= s0 + taef_pkg::SUM_W'(rd_data[7:0]);
          ncount <= ncount + 1'b1;
        end
      end
    end
  end

  // Restoring divider, one quotient bit per cycle for all three channels.
  always_comb begin
    st0 = div_step(r0, q0[taef_pkg::QUO_W-1], ncount);
    st1 = div_step(r1, q1[taef_pkg::QUO_W-1], ncount);
    st2 = div_step(r2, q2[taef_pkg::QUO_W-1], ncount);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.accept) begin
      dcnt <= '0;
    end else if (cmd.divide) begin
      dcnt <= dcnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.divide) begin
      if (dcnt == '0) begin
        q0 <= s0[taef_pkg::QUO_W-1:0];
        q1 <= s1[taef_pkg::QUO_W-1:0];
        q2 <= s2[taef_pkg::QUO_W-1:0];
        r0 <= s0[taef_pkg::SUM_W-1:taef_pkg::QUO_W];
        r1 <= s1[taef_pkg::SUM_W-1:taef_pkg::QUO_W];
        r2 <= s2[taef_pkg::SUM_W-1:taef_pkg::QUO_W];
      end else begin
        q0 <= {q0[taef_pkg::QUO_W-2:0], st0[taef_pkg::REM_W]};
        q1 <= {q1[taef_pkg::QUO_W-2:0], st1[taef_pkg::REM_W]};
        q2 <= {q2[taef_pkg::QUO_W-2:0], st2[taef_pkg::REM_W]};
        r0 <= st0[taef_pkg::REM_W-1:0];
        r1 <= st1[taef_pkg::REM_W-1:0];
        r2 <= st2[taef_pkg::REM_W-1:0];
      end
    end
  end

  // Result texel and tracker updates.
  always_comb begin
    if (!fill_reg || (center[31:24] == taef_pkg::ALPHA_OPAQUE)) begin
      res = center;
    end else if (ncount == '0) begin
      res = {8'h00, center[23:0]};
    end else begin
      res = {8'h00, q2, q1, q0};
    end
    need_next = alpha_need;
    if (alpha_need != taef_pkg::CLASS_FULL) begin
      if (res[31:24] == 8'h00) begin
        need_next = taef_pkg::CLASS_BINARY;
      end else if (res[31:24] < taef_pkg::ALPHA_FULL_LIM) begin
        need_next = taef_pkg::CLASS_FULL;
      end
    end
    gray_next = gray_flag;
    if ((absdiff(res[23:16], res[15:8]) > taef_pkg::GRAY_TOL) ||
        (absdiff(res[23:16], res[7:0]) > taef_pkg::GRAY_TOL) ||
        (absdiff(res[15:8], res[7:0]) > taef_pkg::GRAY_TOL)) begin
      gray_next = 1'b0;
    end
    is_last = ((out_row + 1'b1) == h_eff) &&
              (((COL_W+1)'(out_col) + 1'b1) == (COL_W+1)'(w_eff));
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_texel <= res;
      out_last  <= is_last;
      out_class <= need_next;
      out_gray  <= gray_next;
    end
  end

  // Configuration, counters and trackers.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= DIM_W'(1);
      height_reg <= DIM_W'(1);
      fill_reg   <= 1'b0;
      in_col     <= '0;
      in_row     <= '0;
      out_col    <= '0;
      out_row    <= '0;
      pending    <= '0;
      alpha_need <= taef_pkg::CLASS_OPAQUE;
      gray_flag  <= 1'b1;
    end else begin
      if (store) begin
        pending <= pending + 1'b1;
        if (col_end) begin
          in_col <= '0;
          in_row <= in_row + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (cmd.emit) begin
        if (is_last) begin
          in_col     <= '0;
          in_row     <= '0;
          out_col    <= '0;
          out_row    <= '0;
          pending    <= '0;
          alpha_need <= taef_pkg::CLASS_OPAQUE;
          gray_flag  <= 1'b1;
        end else begin
          pending    <= pending - 1'b1;
          alpha_need <= need_next;
          gray_flag  <= gray_next;
          if (((COL_W+1)'(out_col) + 1'b1) == (COL_W+1)'(w_eff)) begin
            out_col <= '0;
            out_row <= out_row + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          taef_pkg::REG_IMAGE_WIDTH, taef_pkg::REG_IMAGE_HEIGHT: begin
            if (cfg_index == taef_pkg::REG_IMAGE_WIDTH) begin
              width_reg <= cfg_data;
            end else begin
              height_reg <= cfg_data;
            end
            in_col     <= '0;
            in_row     <= '0;
            out_col    <= '0;
            out_row    <= '0;
            pending    <= '0;
            alpha_need <= taef_pkg::CLASS_OPAQUE;
            gray_flag  <= 1'b1;
          end
          taef_pkg::REG_FILL_ENABLE: fill_reg <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/taef_checker.sv =====
`timescale 1ns / 1ps

module taef_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [2:0]  m_axis_tuser
);

  // The output register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // The alpha class never takes the unused code.
  a_class_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser[1:0] != 2'd3))
    else $error("alpha class out of range");

  // A new result is loaded only from the busy part of the sequence.
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while input side was idle");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind texture_alpha_edge_fill_analyze_core taef_checker u_taef_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
